>>> hw/rtl/space_saving_flow_counter_defines.svh
// assertion macros used by the rtl
`ifndef SPACE_SAVING_FLOW_COUNTER_DEFINES_SVH
`define SPACE_SAVING_FLOW_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
`define SSFC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m check failed");
`define SSFC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("%m check failed");
`else
`define SSFC_ASSERT(name, clk, rst, prop)
`define SSFC_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> hw/rtl/ssfc_pkg.sv
package ssfc_pkg;

  localparam int KEY_W = 104;
  localparam int CNT_W = 16;
  // wide enough for the largest table size supported
  localparam int IDX_MAX_W = 6;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [IDX_MAX_W-1:0] slot_id_t;

  // search token walking the cell chain
  typedef struct packed {
    logic     valid;
    key_t     key;
    logic     hit;
    slot_id_t hit_idx;
    count_t   hit_count;
    count_t   hit_over;
    count_t   low_count;
    slot_id_t min_idx;
  } tok_t;

  // broadcast slot update
  typedef struct packed {
    logic     en;
    slot_id_t idx;
    key_t     key;
    count_t   count;
    count_t   over;
  } wr_t;

  function automatic count_t sat_inc(count_t c);
    count_t r;
    r = (c == COUNT_MAX) ? c : c + count_t'(1);
    return r;
  endfunction

endpackage

>>> hw/rtl/ssfc_cell.sv
module ssfc_cell #(
  parameter int CELL_ID = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  ssfc_pkg::tok_t tok_in,
  output ssfc_pkg::tok_t tok_out,
  input  ssfc_pkg::wr_t  wr
);
  import ssfc_pkg::*;

  localparam slot_id_t ID = slot_id_t'(CELL_ID);

  key_t   key;
  count_t count;
  count_t over;
  tok_t   tok;
  tok_t   tok_next;

  logic match;
  logic take_hit;
  logic take_min;

  always_comb begin
    match    = tok_in.valid && (key == tok_in.key);
    take_hit = match && !tok_in.hit;
    // the first cell always seeds the running minimum
    take_min = (CELL_ID == 0) || (count < tok_in.low_count);
    tok_next = tok_in;
    tok_next.hit = tok_in.hit | match;
    if (take_hit) begin
      tok_next.hit_idx   = ID;
      tok_next.hit_count = count;
      tok_next.hit_over  = over;
    end
    if (take_min) begin
      tok_next.low_count = count;
      tok_next.min_idx   = ID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      count <= '0;
      over  <= '0;
    end else if (wr.en && wr.idx == ID) begin
      key   <= wr.key;
      count <= wr.count;
      over  <= wr.over;
    end
  end

  assign tok_out = tok;

endmodule

>>> hw/rtl/space_saving_flow_counter.sv
// Space-saving heavy-hitter table with NUM_SLOTS slots, one slot per cell in a chain. A packet
// beat is taken only when the block is idle; its search token then walks the chain one cell per
// cycle, picking up the first matching slot and the smallest count (lowest slot on ties). Once it
// leaves the last cell it is captured in the hold register; the chosen slot is then written and the
// result loaded into the output register in the same cycle, once that register is free. A packet
// occupies the block until that write, and the next packet beat can be taken right after the write
// even while the result still waits. Counts saturate at 65535; slot_index carries the low three
// bits of the slot number.
`include "space_saving_flow_counter_defines.svh"

module space_saving_flow_counter #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  protocol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  slot_index,
  output logic        was_hit,
  output logic [15:0] new_count,
  output logic [15:0] overestimate
);
  import ssfc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  tok_t head;
  tok_t chain [NUM_SLOTS+1];
  tok_t hold;
  wr_t  wr;
  logic [NUM_SLOTS-1:0] tok_valid;

  logic accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    head           = '0;
    head.valid     = accept;
    head.key       = {source_address, dest_address, source_port, dest_port, protocol};
    head.low_count = COUNT_MAX;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ssfc_cell #(
      .CELL_ID(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[i]),
      .tok_out(chain[i+1]),
      .wr     (wr)
    );
    assign tok_valid[i] = chain[i+1].valid;
  end

  always_comb begin
    wr.en    = (state == ST_WRITE) && (!out_valid || !out_stall);
    wr.key   = hold.key;
    wr.idx   = hold.hit ? hold.hit_idx : hold.min_idx;
    wr.count = hold.hit ? sat_inc(hold.hit_count) : sat_inc(hold.low_count);
    wr.over  = hold.hit ? hold.hit_over : hold.low_count;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (chain[NUM_SLOTS].valid) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (wr.en) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && chain[NUM_SLOTS].valid) begin
      hold <= chain[NUM_SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr.en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_index   <= wr.idx[2:0];
      was_hit      <= hold.hit;
      new_count    <= wr.count;
      overestimate <= wr.over;
    end
  end

  // only one search token in flight at a time
  `SSFC_ASSERT(a_one_token, clk, rst, $onehot0(tok_valid))
  // the token leaves the chain only while scanning
  `SSFC_ASSERT(a_tail_in_scan, clk, rst, chain[NUM_SLOTS].valid |-> state == ST_SCAN)
  // a slot update always produces a result beat
  `SSFC_ASSERT(a_write_result, clk, rst, wr.en |=> out_valid)
  // every update leaves the slot with a nonzero count
  `SSFC_ASSERT(a_count_nonzero, clk, rst, out_valid |-> new_count != 16'h0000)

endmodule

>>> verif/space_saving_flow_counter_tb.sv
`timescale 1ns / 100ps

module space_saving_flow_counter_tb;
  import ssfc_pkg::*;

  localparam int SLOTS = 8;
  localparam int POOL_SIZE = 14;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int HOT_RUN = 40;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } flow_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       hit;
    count_t     count;
    count_t     over;
  } tally_t;

  // mirror of the heavy-hitter table plus the tallies still owed by the block
  class flow_table_scoreboard;
    key_t   keys[SLOTS];
    count_t counts[SLOTS];
    count_t overs[SLOTS];
    tally_t pending[$];
    int     mismatches;
    int     checked;
    int     hits;
    int     takeovers;
    int     at_ceiling;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        keys[s] = '0;
        counts[s] = '0;
        overs[s] = '0;
      end
      mismatches = 0;
      checked = 0;
      hits = 0;
      takeovers = 0;
      at_ceiling = 0;
    endfunction

    function void note_packet(key_t k);
      int     s;
      int     pick;
      logic   hit;
      count_t minc;
      tally_t t;
      hit = 1'b0;
      pick = 0;
      for (s = 0; s < SLOTS; s++) begin
        if (!hit && keys[s] == k) begin
          hit = 1'b1;
          pick = s;
        end
      end
      if (hit) begin
        if (counts[pick] != COUNT_MAX) counts[pick] = counts[pick] + count_t'(1);
      end else begin
        // lowest slot wins a tie on the smallest count
        minc = counts[0];
        for (s = 1; s < SLOTS; s++) begin
          if (counts[s] < minc) begin
            minc = counts[s];
            pick = s;
          end
        end
        keys[pick] = k;
        overs[pick] = minc;
        counts[pick] = (minc == COUNT_MAX) ? minc : minc + count_t'(1);
      end
      t.slot = pick[2:0];
      t.hit = hit;
      t.count = counts[pick];
      t.over = overs[pick];
      pending.push_back(t);
    endfunction

    function void check_result(logic [2:0] slot, logic hit, count_t count, count_t over);
      tally_t t;
      if (pending.size() == 0) begin
        $error("result beat with no packet outstanding: slot %0d count %0d", slot, count);
        mismatches++;
        return;
      end
      t = pending.pop_front();
      checked++;
      if (t.hit) hits++;
      else takeovers++;
      if (t.count == COUNT_MAX) at_ceiling++;
      if (slot !== t.slot) begin
        $error("slot_index: expected %0d, got %0d", t.slot, slot);
        mismatches++;
      end
      if (hit !== t.hit) begin
        $error("was_hit: expected %0d, got %0d", t.hit, hit);
        mismatches++;
      end
      if (count !== t.count) begin
        $error("new_count: expected %0d, got %0d", t.count, count);
        mismatches++;
      end
      if (over !== t.over) begin
        $error("overestimate: expected %0d, got %0d", t.over, over);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  protocol;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  slot_index;
  logic        was_hit;
  logic [15:0] new_count;
  logic [15:0] overestimate;

  flow_table_scoreboard sb;
  flow_t pool[POOL_SIZE];
  int    send_idle_pct;
  int    stall_pct;
  int    quiet_cycles;

  space_saving_flow_counter #(
    .NUM_SLOTS(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .source_address(source_address),
    .dest_address(dest_address),
    .source_port(source_port),
    .dest_port(dest_port),
    .protocol(protocol),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .slot_index(slot_index),
    .was_hit(was_hit),
    .new_count(new_count),
    .overestimate(overestimate)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(slot_index, was_hit, new_count, overestimate);
      end
      if (in_valid && !in_stall) begin
        sb.note_packet(key_t'({source_address, dest_address, source_port, dest_port,
                               protocol}));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic flow_t make_flow(logic [31:0] src, logic [31:0] dst, logic [15:0] sport,
                                      logic [15:0] dport, logic [7:0] proto);
    flow_t f;
    f.src = src;
    f.dst = dst;
    f.sport = sport;
    f.dport = dport;
    f.proto = proto;
    return f;
  endfunction

  // mostly uniform fields, with the odd extreme value mixed in
  function automatic logic [31:0] pick_field(logic [31:0] mask);
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return mask;
    return $urandom & mask;
  endfunction

  function automatic flow_t random_flow();
    flow_t f;
    f.src = pick_field(32'hFFFF_FFFF);
    f.dst = pick_field(32'hFFFF_FFFF);
    f.sport = 16'(pick_field(32'h0000_FFFF));
    f.dport = 16'(pick_field(32'h0000_FFFF));
    f.proto = 8'(pick_field(32'h0000_00FF));
    return f;
  endfunction

  task automatic send_packet(input flow_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      {source_address, dest_address, source_port, dest_port, protocol} <= random_flow();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {source_address, dest_address, source_port, dest_port, protocol} <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // skewed picks from a flow pool larger than the table, so slots churn
  task automatic run_traffic(input int n);
    int    roll;
    flow_t f;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = random_flow();
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 50) f = pool[$urandom_range(3)];
      else if (roll < 78) f = pool[$urandom_range(POOL_SIZE - 1)];
      else if (roll < 84) f = flow_t'(key_t'(pool[$urandom_range(POOL_SIZE - 1)]) ^
                                      (key_t'(1) << $urandom_range(KEY_W - 1)));
      else f = random_flow();
      send_packet(f);
    end
  endtask

  initial begin
    flow_t hot;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {source_address, dest_address, source_port, dest_port, protocol} = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // all-zero key lands on the empty slot 0 as a hit, then fill the table
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_packet(make_flow(32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'h0, 32'h0, 16'hFFFF, 16'h0, 8'h0));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'hFFFF, 8'h0));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'h0, 8'hFF));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'h0, 8'h01));
    send_packet(make_flow(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    // table full: misses take the lowest slot among the tied minimum counts
    send_packet(make_flow(32'h8000_0000, 32'h0, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'h0, 8'hFF));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'h0, 8'h01));
    send_packet(make_flow(32'h0, 32'h0, 16'h0001, 16'h0, 8'h0));
    send_packet(make_flow(32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'h8000_0000, 32'h0, 16'h0, 16'h0, 8'h0));
    send_packet(make_flow(32'h0A00_0001, 32'hC0A8_0101, 16'd443, 16'd51000, 8'd6));
    send_packet(make_flow(32'h0A00_0001, 32'hC0A8_0101, 16'd443, 16'd51000, 8'd17));
    send_packet(make_flow(32'h0A00_0001, 32'hC0A8_0101, 16'd443, 16'd51000, 8'd6));
    send_packet(make_flow(32'h0, 32'h0, 16'h0, 16'hFFFF, 8'h0));
    send_packet(make_flow(32'h0, 32'h0, 16'hFFFF, 16'h0, 8'h0));
    wait_idle();

    send_idle_pct = 0;
    stall_pct = 0;
    run_traffic(400);
    wait_idle();
    send_idle_pct = 55;
    stall_pct = 0;
    run_traffic(400);
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 55;
    run_traffic(400);
    wait_idle();
    send_idle_pct = 7;
    stall_pct = 7;
    run_traffic(400);
    wait_idle();

    // one flow hammered back to back so it holds its slot, then some churn
    send_idle_pct = 0;
    stall_pct = 0;
    hot = random_flow();
    repeat (HOT_RUN) send_packet(hot);
    send_idle_pct = 7;
    stall_pct = 7;
    run_traffic(30);
    send_packet(hot);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d results checked: %0d flow hits, %0d slot takeovers",
             sb.checked, sb.hits, sb.takeovers);
    $display("%0d results reported a saturated count", sb.at_ceiling);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
